FILE: hw/rtl/pli_pkg.sv
// Shared types, constants and the arctangent table of the phase lag index block.
// No dependencies; every other file imports this package.
package pli_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int GUARD_BITS   = 30 - SAMPLE_BITS;
  // Complex working data: every value stays within about 2^31 after doubling.
  localparam int DW           = 34;
  // CORDIC angle accumulator, in 2^-32 turn units.
  localparam int ZW           = 34;
  // Phase CORDIC datapath after the 2^28 prescale.
  localparam int PW           = 64;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [DW-1:0] TW_X0 = 34'sd652032874;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic                          last;
  } pli_in_t;

  typedef struct packed {
    logic [16:0] pli_q16;
    logic [10:0] positive_count;
    logic [10:0] nonzero_count;
    logic        overflow;
  } pli_out_t;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
  } cplx_t;

  typedef enum logic [4:0] {
    S_LOAD, S_PREP, S_PAD,
    S_RV_CHK, S_RV_RD0, S_RV_RD1, S_RV_W0, S_RV_W1,
    S_ST, S_TW, S_TW_WAIT,
    S_B_RD0, S_B_RD1, S_B_MUL, S_B_WP, S_B_WQ,
    S_SC_RD, S_SC_WR,
    S_PH_RD, S_PH_GO, S_PH_WAIT,
    S_DIV, S_DIV_WAIT, S_OUT
  } pli_state_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/pli_twiddle.sv
// Iterative CORDIC rotation that produces one Q30 twiddle (cos, sin).
// Depends on pli_pkg for widths and the arctangent table.
module pli_twiddle import pli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [31:0]          ang,
  output logic signed [DW-1:0] cos_o,
  output logic signed [DW-1:0] sin_o,
  output logic                 done
);

  logic signed [DW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic                 flip_r;
  logic                 busy_r, done_r;
  logic [4:0]           step_r;
  logic [31:0]          ang_sum, ang_fold;
  logic                 flip_w;
  logic signed [ZW-1:0] at_w;

  always_comb begin
    ang_sum  = ang + 32'h4000_0000;
    flip_w   = ang_sum >= 32'h8000_0000;
    ang_fold = flip_w ? ang + 32'h8000_0000 : ang;
    at_w     = signed'({{(ZW-32){1'b0}}, atan_turn(step_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= TW_X0;
      y_r    <= '0;
      z_r    <= signed'({{(ZW-32){ang_fold[31]}}, ang_fold});
      flip_r <= flip_w;
    end else if (busy_r) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - (y_r >>> step_r);
        y_r <= y_r + (x_r >>> step_r);
        z_r <= z_r - at_w;
      end else begin
        x_r <= x_r + (y_r >>> step_r);
        y_r <= y_r - (x_r >>> step_r);
        z_r <= z_r + at_w;
      end
    end
  end

  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;
  assign done  = done_r;

endmodule

FILE: hw/rtl/pli_phase.sv
// Iterative CORDIC vectoring unit: the turn angle of one complex point.
// Depends on pli_pkg for widths and the arctangent table.
module pli_phase import pli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] x_in,
  input  logic signed [DW-1:0] y_in,
  output logic signed [ZW-1:0] ang,
  output logic                 done
);

  logic signed [PW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r, base_r;
  logic                 busy_r, done_r, hold_r;
  logic [4:0]           step_r;
  logic signed [PW-1:0] xs, ys;
  logic signed [ZW-1:0] at_w;

  always_comb begin
    xs   = PW'(x_in) <<< 28;
    ys   = PW'(y_in) <<< 28;
    at_w = signed'({{(ZW-32){1'b0}}, atan_turn(step_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 5'd1;
        if (step_r == 5'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z_r    <= '0;
      hold_r <= 1'b0;
      if (y_in == '0 && x_in < 0) begin
        // A point on the negative real axis is exactly half a turn.
        base_r <= ZW'(64'sd2147483648);
        hold_r <= 1'b1;
        x_r    <= xs;
        y_r    <= ys;
      end else if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r    <= ys;
          y_r    <= -xs;
          base_r <= ZW'(64'sd1073741824);
        end else begin
          x_r    <= -ys;
          y_r    <= xs;
          base_r <= -ZW'(64'sd1073741824);
        end
      end else begin
        x_r    <= xs;
        y_r    <= ys;
        base_r <= '0;
      end
    end else if (busy_r && !hold_r && y_r != '0) begin
      if (y_r > 0) begin
        x_r <= x_r + (y_r >>> step_r);
        y_r <= y_r - (x_r >>> step_r);
        z_r <= z_r + at_w;
      end else begin
        x_r <= x_r - (y_r >>> step_r);
        y_r <= y_r + (x_r >>> step_r);
        z_r <= z_r - at_w;
      end
    end
  end

  assign ang  = base_r + z_r;
  assign done = done_r;

endmodule

FILE: hw/rtl/pli_bfly.sv
// Radix-2 butterfly datapath with registered products and halving outputs.
// Depends on pli_pkg for the complex type.
module pli_bfly import pli_pkg::*; (
  input  logic                 clk,
  input  logic                 mul_en,
  input  cplx_t                a,
  input  cplx_t                b,
  input  logic signed [DW-1:0] wr,
  input  logic signed [DW-1:0] wi,
  output cplx_t                p,
  output cplx_t                q
);

  localparam int MW = 2 * DW + 1;
  localparam logic signed [MW-1:0] RND = MW'(64'sd536870912);

  cplx_t                a_r;
  logic signed [2*DW-1:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [MW-1:0] sr, si, tr, ti, pr, pi, qr, qi;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      a_r  <= a;
      m_rr <= b.re * wr;
      m_ii <= b.im * wi;
      m_ri <= b.re * wi;
      m_ir <= b.im * wr;
    end
  end

  always_comb begin
    sr = MW'(m_rr) - MW'(m_ii) + RND;
    si = MW'(m_ri) + MW'(m_ir) + RND;
    tr = sr >>> 30;
    ti = si >>> 30;
    pr = (MW'(a_r.re) + tr) >>> 1;
    pi = (MW'(a_r.im) + ti) >>> 1;
    qr = (MW'(a_r.re) - tr) >>> 1;
    qi = (MW'(a_r.im) - ti) >>> 1;
    p.re = pr[DW-1:0];
    p.im = pi[DW-1:0];
    q.re = qr[DW-1:0];
    q.im = qi[DW-1:0];
  end

endmodule

FILE: hw/rtl/pli_div.sv
// Restoring divider for floor(diff * 65536 / den), one quotient bit per cycle.
// Depends on pli_pkg only through the import convention.
module pli_div import pli_pkg::*; #(
  parameter int CW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] num,
  input  logic [CW-1:0] den,
  output logic [16:0]   quo,
  output logic          done
);

  localparam int NW = CW + 16;
  localparam int SW = $clog2(NW + 1);

  logic [CW:0]   rem_r;
  logic [NW-1:0] num_r, quo_r;
  logic [SW-1:0] step_r;
  logic          busy_r, done_r;
  logic [CW:0]   rem_s;
  logic          ge;

  always_comb begin
    rem_s = {rem_r[CW-1:0], num_r[NW-1]};
    ge    = rem_s >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + SW'(1);
        if (step_r == SW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= {num, 16'd0};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_s - {1'b0, den} : rem_s;
      num_r <= {num_r[NW-2:0], 1'b0};
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign quo  = quo_r[16:0];
  assign done = done_r;

endmodule

FILE: hw/rtl/phase_lag_index_top.sv
// Phase lag index of two series: loads sample pairs into two complex memories, runs
// forward and inverse in-place FFTs, CORDIC phases and a divider from one sequencer.
//
// Sample pairs are taken one per cycle until the request marked last; pairs beyond
// MAX_POINTS are dropped and flagged. A series is then padded to a power-of-two length
// N, bit-reversed, transformed forward, rescaled, transformed back, phased and divided.
// The FFT runs each butterfly through the single read port of each memory and takes
// each twiddle from a shared rotator, and each point then waits for its phase. Both
// series are processed in lockstep. The result sits in an output register, and the
// next series loads once it has been taken or is pending alone. Memories have no
// reset; padding is written before any read.
module phase_lag_index_top import pli_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int PHASE_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pli_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pli_out_t out_data
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int KW    = AW + 2;
  localparam int LW    = $clog2(AW + 1);
  localparam int STW   = $clog2(AW + 2);

  pli_state_t state_r, state_nxt;

  logic [CW-1:0]  cnt_r, cnt_nxt, pos_r, pos_nxt, nz_r, nz_nxt;
  logic           ovf_r, ovf_nxt, inv_r, inv_nxt;
  logic [LW-1:0]  lg_r, lg_nxt;
  logic [KW-1:0]  i_r, i_nxt, j_r, j_nxt;
  logic [STW-1:0] st_r, st_nxt;
  cplx_t          hold_a_r, hold_a_nxt, hold_b_r, hold_b_nxt;
  pli_out_t       out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  cplx_t          mem_a [DEPTH];
  cplx_t          mem_b [DEPTH];
  cplx_t          rd_a_r, rd_b_r, wd_a, wd_b;
  logic           we;
  logic [AW-1:0]  waddr, raddr;

  logic           tw_start, tw_done, ph_start, pha_done, phb_done, div_start, div_done;
  logic           mul_en;
  logic [31:0]    tw_ang, ang_f;
  logic signed [DW-1:0] tw_c, tw_s;
  logic signed [ZW-1:0] pha_ang, phb_ang, pa, pb;
  cplx_t          bfa_p, bfa_q, bfb_p, bfb_q;
  logic [16:0]    div_q;
  logic [CW-1:0]  diff_w;
  logic [CW:0]    two_pos;

  logic [KW-1:0]  n_w, h_w, ih_w, i2h_w, half_w;
  logic [AW-1:0]  rev_full, r_w;
  logic [LW-1:0]  lg_calc;
  logic [5:0]     sh_w;
  logic signed [DW-1:0] sa_ext, sb_ext;

  always_comb begin
    n_w    = KW'(1) << lg_r;
    half_w = n_w >> 1;
    h_w    = KW'(1) << (st_r - STW'(1));
    ih_w   = i_r + h_w;
    i2h_w  = i_r + (h_w << 1);
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = i_r[AW-1-b];
    end
    r_w = rev_full >> (LW'(AW) - lg_r);
    lg_calc = '0;
    for (int b = 0; b < AW; b++) begin
      if (cnt_r > (CW'(1) << b)) lg_calc = LW'(b + 1);
    end
    sh_w   = 6'd32 - 6'(st_r);
    ang_f  = 32'(j_r) << sh_w;
    tw_ang = inv_r ? 32'd0 - ang_f : ang_f;
    sa_ext = DW'(in_data.sample_a) <<< GUARD_BITS;
    sb_ext = DW'(in_data.sample_b) <<< GUARD_BITS;
    pa     = pha_ang >>> (32 - PHASE_BITS);
    pb     = phb_ang >>> (32 - PHASE_BITS);
    two_pos = {pos_r, 1'b0};
    diff_w = ({1'b0, nz_r} >= two_pos) ? CW'({1'b0, nz_r} - two_pos)
                                       : CW'(two_pos - {1'b0, nz_r});
  end

  // Working stores for series A and B; both see the same addresses.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wd_a;
      mem_b[waddr] <= wd_b;
    end
    rd_a_r <= mem_a[raddr];
    rd_b_r <= mem_b[raddr];
  end

  pli_twiddle u_tw (
    .clk(clk), .rst_n(rst_n), .start(tw_start), .ang(tw_ang),
    .cos_o(tw_c), .sin_o(tw_s), .done(tw_done)
  );

  pli_bfly u_bfa (
    .clk(clk), .mul_en(mul_en), .a(hold_a_r), .b(rd_a_r), .wr(tw_c), .wi(tw_s),
    .p(bfa_p), .q(bfa_q)
  );

  pli_bfly u_bfb (
    .clk(clk), .mul_en(mul_en), .a(hold_b_r), .b(rd_b_r), .wr(tw_c), .wi(tw_s),
    .p(bfb_p), .q(bfb_q)
  );

  // The inverse transform's imaginary part is negated on the way into the phase units.
  pli_phase u_pha (
    .clk(clk), .rst_n(rst_n), .start(ph_start), .x_in(rd_a_r.re), .y_in(-rd_a_r.im),
    .ang(pha_ang), .done(pha_done)
  );

  pli_phase u_phb (
    .clk(clk), .rst_n(rst_n), .start(ph_start), .x_in(rd_b_r.re), .y_in(-rd_b_r.im),
    .ang(phb_ang), .done(phb_done)
  );

  pli_div #(.CW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(diff_w), .den(nz_r),
    .quo(div_q), .done(div_done)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:    if (in_valid && in_data.last) state_nxt = S_PREP;
      S_PREP:    state_nxt = S_PAD;
      S_PAD:     if (i_r >= n_w) state_nxt = S_RV_CHK;
      S_RV_CHK: begin
        if (i_r >= n_w) state_nxt = S_ST;
        else if (r_w > i_r[AW-1:0]) state_nxt = S_RV_RD0;
      end
      S_RV_RD0:  state_nxt = S_RV_RD1;
      S_RV_RD1:  state_nxt = S_RV_W0;
      S_RV_W0:   state_nxt = S_RV_W1;
      S_RV_W1:   state_nxt = S_RV_CHK;
      S_ST: begin
        if (st_r > STW'(lg_r)) state_nxt = inv_r ? S_PH_RD : S_SC_RD;
        else state_nxt = S_TW;
      end
      S_TW:      state_nxt = S_TW_WAIT;
      S_TW_WAIT: if (tw_done) state_nxt = S_B_RD0;
      S_B_RD0:   state_nxt = S_B_RD1;
      S_B_RD1:   state_nxt = S_B_MUL;
      S_B_MUL:   state_nxt = S_B_WP;
      S_B_WP:    state_nxt = S_B_WQ;
      S_B_WQ: begin
        if (i2h_w < n_w) state_nxt = S_B_RD0;
        else if (j_r + KW'(1) < h_w) state_nxt = S_TW;
        else state_nxt = S_ST;
      end
      S_SC_RD:   state_nxt = (i_r >= n_w) ? S_RV_CHK : S_SC_WR;
      S_SC_WR:   state_nxt = S_SC_RD;
      S_PH_RD:   state_nxt = (i_r >= n_w) ? S_DIV : S_PH_GO;
      S_PH_GO:   state_nxt = S_PH_WAIT;
      S_PH_WAIT: if (pha_done) state_nxt = S_PH_RD;
      S_DIV:     state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r) state_nxt = S_LOAD;
      default:   state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    we            = 1'b0;
    waddr         = i_r[AW-1:0];
    raddr         = i_r[AW-1:0];
    wd_a          = '0;
    wd_b          = '0;
    tw_start      = 1'b0;
    ph_start      = 1'b0;
    div_start     = 1'b0;
    mul_en        = 1'b0;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    lg_nxt        = lg_r;
    inv_nxt       = inv_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    nz_nxt        = nz_r;
    hold_a_nxt    = hold_a_r;
    hold_b_nxt    = hold_b_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt_r < CW'(MAX_POINTS)) begin
            we      = 1'b1;
            waddr   = cnt_r[AW-1:0];
            wd_a.re = sa_ext;
            wd_b.re = sb_ext;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_PREP: begin
        lg_nxt  = lg_calc;
        i_nxt   = KW'(cnt_r);
        inv_nxt = 1'b0;
        pos_nxt = '0;
        nz_nxt  = '0;
      end
      S_PAD: begin
        if (i_r < n_w) begin
          we    = 1'b1;
          i_nxt = i_r + KW'(1);
        end else begin
          i_nxt = '0;
        end
      end
      S_RV_CHK: begin
        if (i_r >= n_w) begin
          st_nxt = STW'(1);
        end else if (!(r_w > i_r[AW-1:0])) begin
          i_nxt = i_r + KW'(1);
        end
      end
      S_RV_RD1: begin
        raddr      = r_w;
        hold_a_nxt = rd_a_r;
        hold_b_nxt = rd_b_r;
      end
      S_RV_W0: begin
        we   = 1'b1;
        wd_a = rd_a_r;
        wd_b = rd_b_r;
      end
      S_RV_W1: begin
        we    = 1'b1;
        waddr = r_w;
        wd_a  = hold_a_r;
        wd_b  = hold_b_r;
        i_nxt = i_r + KW'(1);
      end
      S_ST: begin
        i_nxt = '0;
        j_nxt = '0;
      end
      S_TW:      tw_start = 1'b1;
      S_TW_WAIT: if (tw_done) i_nxt = j_r;
      S_B_RD1: begin
        raddr      = ih_w[AW-1:0];
        hold_a_nxt = rd_a_r;
        hold_b_nxt = rd_b_r;
      end
      S_B_MUL:   mul_en = 1'b1;
      S_B_WP: begin
        we   = 1'b1;
        wd_a = bfa_p;
        wd_b = bfb_p;
      end
      S_B_WQ: begin
        we    = 1'b1;
        waddr = ih_w[AW-1:0];
        wd_a  = bfa_q;
        wd_b  = bfb_q;
        i_nxt = i2h_w;
        if (!(i2h_w < n_w)) begin
          if (j_r + KW'(1) < h_w) j_nxt = j_r + KW'(1);
          else st_nxt = st_r + STW'(1);
        end
      end
      S_SC_RD: begin
        if (i_r >= n_w) begin
          inv_nxt = 1'b1;
          i_nxt   = '0;
        end
      end
      S_SC_WR: begin
        // Positive-frequency bins are doubled, negative-frequency bins cleared, DC and Nyquist kept.
        we = 1'b1;
        if (i_r >= KW'(1) && i_r < half_w) begin
          wd_a.re = rd_a_r.re <<< 1;
          wd_a.im = rd_a_r.im <<< 1;
          wd_b.re = rd_b_r.re <<< 1;
          wd_b.im = rd_b_r.im <<< 1;
        end else if (i_r <= half_w) begin
          wd_a = rd_a_r;
          wd_b = rd_b_r;
        end
        i_nxt = i_r + KW'(1);
      end
      S_PH_GO:   ph_start = 1'b1;
      S_PH_WAIT: begin
        if (pha_done) begin
          i_nxt = i_r + KW'(1);
          if (pa > pb) begin
            pos_nxt = pos_r + CW'(1);
            nz_nxt  = nz_r + CW'(1);
          end else if (pa < pb) begin
            nz_nxt = nz_r + CW'(1);
          end
        end
      end
      S_DIV:     div_start = 1'b1;
      S_OUT: begin
        if (!out_valid_r) begin
          out_nxt.pli_q16        = (nz_r == '0) ? 17'd0 : div_q;
          out_nxt.positive_count = 11'(pos_r);
          out_nxt.nonzero_count  = 11'(nz_r);
          out_nxt.overflow       = ovf_r;
          out_valid_nxt          = 1'b1;
          cnt_nxt                = '0;
          ovf_nxt                = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      lg_r        <= '0;
      inv_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      st_r        <= '0;
      pos_r       <= '0;
      nz_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      lg_r        <= lg_nxt;
      inv_r       <= inv_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      st_r        <= st_nxt;
      pos_r       <= pos_nxt;
      nz_r        <= nz_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_a_r <= hold_a_nxt;
    hold_b_r <= hold_b_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_phase_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    pha_done == phb_done) else $error("phase units out of step");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS)) else $error("sample count beyond capacity");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (cnt_r == '0 && !ovf_r))
    else $error("load state not cleared with result");

  a_lg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> lg_r <= LW'(AW)) else $error("transform size too large");

endmodule

FILE: dv/pli_checker.sv
// Checker for the phase lag index block: watches both channels, predicts each result
// from the accepted sample pairs and compares it field by field. Depends on pli_pkg.
module pli_checker import pli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  pli_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  pli_out_t out_data,
  output int       errors,
  output int       pending
);

  localparam int MAXP = 1024;

  longint ser_a[MAXP];
  longint ser_b[MAXP];
  longint buf_re[MAXP];
  longint buf_im[MAXP];
  longint phase_a[MAXP];
  int     loaded;
  bit     dropped;
  int     err_cnt;
  int     exp_cnt;

  pli_out_t pli_expected[$];

  assign errors  = err_cnt;
  assign pending = exp_cnt;

  function automatic void rotate_twiddle(input logic [31:0] ang, output longint c,
                                         output longint s);
    logic [31:0] shifted;
    bit          flip;
    longint      x, y, z, nx, step_ang;
    shifted = ang + 32'h40000000;
    flip = (shifted >= 32'h80000000);
    if (flip) ang = ang + 32'h80000000;
    z = longint'($signed(ang));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      step_ang = longint'({32'b0, atan_turn(5'(i))});
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - step_ang;
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + step_ang;
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // In-place radix-2 transform of buf_re/buf_im; every stage halves the data.
  function automatic void transform_buf(input int lg, input bit inv);
    int          n, r, h;
    longint      t, wr, wi, tr, ti, ar, ai;
    logic [31:0] ang;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r = (r << 1) | ((i >> b) & 1);
      if (r > i) begin
        t = buf_re[i]; buf_re[i] = buf_re[r]; buf_re[r] = t;
        t = buf_im[i]; buf_im[i] = buf_im[r]; buf_im[r] = t;
      end
    end
    for (int st = 1; st <= lg; st++) begin
      h = 1 << (st - 1);
      for (int j = 0; j < h; j++) begin
        ang = 32'(j) << (32 - st);
        rotate_twiddle(inv ? 32'd0 - ang : ang, wr, wi);
        for (int k = j; k < n; k += 2 * h) begin
          tr = (buf_re[k+h] * wr - buf_im[k+h] * wi + (64'sd1 <<< 29)) >>> 30;
          ti = (buf_re[k+h] * wi + buf_im[k+h] * wr + (64'sd1 <<< 29)) >>> 30;
          ar = buf_re[k];
          ai = buf_im[k];
          buf_re[k]   = (ar + tr) >>> 1;
          buf_im[k]   = (ai + ti) >>> 1;
          buf_re[k+h] = (ar - tr) >>> 1;
          buf_im[k+h] = (ai - ti) >>> 1;
        end
      end
    end
  endfunction

  function automatic void analytic_buf(input int lg);
    int n;
    n = 1 << lg;
    transform_buf(lg, 1'b0);
    for (int k = 1; k < n / 2; k++) begin
      buf_re[k] = buf_re[k] * 2;
      buf_im[k] = buf_im[k] * 2;
    end
    for (int k = n / 2 + 1; k < n; k++) begin
      buf_re[k] = 0;
      buf_im[k] = 0;
    end
    transform_buf(lg, 1'b1);
    for (int k = 0; k < n; k++) buf_im[k] = -buf_im[k];
  endfunction

  function automatic longint phase_turns(input longint x, input longint y);
    longint base, z, t, nx, step_ang;
    base = 0;
    z = 0;
    if (y == 0) begin
      if (x == 0) return 0;
      if (x < 0) return (64'sd1 <<< 31) >>> (32 - 16);
    end
    x = x * (64'sd1 <<< 28);
    y = y * (64'sd1 <<< 28);
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; base = 64'sd1 <<< 30;
      end else begin
        x = -y; y = t; base = -(64'sd1 <<< 30);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y == 0) break;
      step_ang = longint'({32'b0, atan_turn(5'(i))});
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + step_ang;
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - step_ang;
      end
      x = nx;
    end
    return (base + z) >>> (32 - 16);
  endfunction

  function automatic pli_out_t predict_pli();
    int       lg, n, pos, nz;
    longint   d, diff, pli;
    pli_out_t r;
    lg = 0;
    while ((1 << lg) < loaded) lg++;
    n = 1 << lg;
    for (int k = loaded; k < n; k++) begin
      ser_a[k] = 0;
      ser_b[k] = 0;
    end
    for (int k = 0; k < n; k++) begin
      buf_re[k] = ser_a[k];
      buf_im[k] = 0;
    end
    analytic_buf(lg);
    for (int k = 0; k < n; k++) phase_a[k] = phase_turns(buf_re[k], buf_im[k]);
    for (int k = 0; k < n; k++) begin
      buf_re[k] = ser_b[k];
      buf_im[k] = 0;
    end
    analytic_buf(lg);
    pos = 0;
    nz = 0;
    for (int k = 0; k < n; k++) begin
      d = phase_a[k] - phase_turns(buf_re[k], buf_im[k]);
      if (d > 0) begin
        pos++; nz++;
      end else if (d < 0) begin
        nz++;
      end
    end
    pli = 0;
    if (nz != 0) begin
      diff = nz - 2 * pos;
      if (diff < 0) diff = -diff;
      pli = (diff * 65536) / nz;
    end
    r.pli_q16        = 17'(pli);
    r.positive_count = 11'(pos);
    r.nonzero_count  = 11'(nz);
    r.overflow       = dropped;
    return r;
  endfunction

  always @(posedge clk) begin
    pli_out_t exp_r;
    if (!rst_n) begin
      loaded  = 0;
      dropped = 0;
      err_cnt = 0;
      exp_cnt = 0;
      pli_expected.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (loaded < MAXP) begin
          ser_a[loaded] = longint'($signed(in_data.sample_a)) * (64'sd1 <<< GUARD_BITS);
          ser_b[loaded] = longint'($signed(in_data.sample_b)) * (64'sd1 <<< GUARD_BITS);
          loaded++;
        end else begin
          dropped = 1;
        end
        if (in_data.last) begin
          pli_expected = {pli_expected, predict_pli()};
          exp_cnt++;
          loaded  = 0;
          dropped = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (pli_expected.size() == 0) begin
          $display("%0t: result with no request pending: %p", $time, out_data);
          err_cnt++;
        end else begin
          exp_r = pli_expected.pop_front();
          exp_cnt--;
          if (out_data.pli_q16 !== exp_r.pli_q16) begin
            $display("%0t: pli_q16 expected %0d got %0d", $time, exp_r.pli_q16,
                     out_data.pli_q16);
            err_cnt++;
          end
          if (out_data.positive_count !== exp_r.positive_count) begin
            $display("%0t: positive_count expected %0d got %0d", $time,
                     exp_r.positive_count, out_data.positive_count);
            err_cnt++;
          end
          if (out_data.nonzero_count !== exp_r.nonzero_count) begin
            $display("%0t: nonzero_count expected %0d got %0d", $time,
                     exp_r.nonzero_count, out_data.nonzero_count);
            err_cnt++;
          end
          if (out_data.overflow !== exp_r.overflow) begin
            $display("%0t: overflow expected %0d got %0d", $time, exp_r.overflow,
                     out_data.overflow);
            err_cnt++;
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb.sv
// Top of the phase lag index testbench: clock, reset, sample-pair stimulus, result
// back-pressure and the verdict. Depends on pli_pkg, phase_lag_index_top and pli_checker.
module tb;
  import pli_pkg::*;

  localparam int IDLE_LIMIT = 600000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  pli_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pli_out_t out_data;
  int       errors, pending;
  int       idle_cycles = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  bit       hold_now = 1'b0;

  phase_lag_index_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  pli_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall patterns switch among three random modes; one long hold on request.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_now) begin
        out_ready <= 1'b0;
        repeat (4000) @(posedge clk);
        hold_now = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(50, 400);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic lst);
    pli_in_t d;
    d.sample_a = a;
    d.sample_b = b;
    d.last     = lst;
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [15:0] pick_sample(input int kind);
    case (kind)
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return 16'h0000;
    endcase
  endfunction

  // Series shapes: independent, B equal to A, B the negation of A, B silent.
  task automatic send_series(input int len, input int shape);
    logic [15:0] a, b;
    int kind;
    kind = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 3);
    for (int i = 0; i < len; i++) begin
      a = pick_sample(kind);
      case (shape)
        0: b = pick_sample(kind);
        1: b = a;
        2: b = -a;
        default: b = 16'h0000;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single pairs and short series at the sample extremes, including the all-zero point.
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'h8000, 16'h0000, 1'b1);
    send_pair(16'h0000, 16'h7FFF, 1'b1);
    send_pair(16'h7FFF, 16'h7FFF, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b1);
    send_series(3, 0);
    send_series(4, 2);
    send_pair(16'h7FFF, 16'h8000, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'hFFFF, 16'h0001, 1'b1);

    // The receiver holds off while short series keep arriving back to back.
    drain_results();
    gaps_on = 1'b0;
    hold_now = 1'b1;
    for (int s = 0; s < 8; s++) send_series(4, 0);
    gaps_on = 1'b1;
    drain_results();

    // A full store followed by dropped pairs; the last mark lands on a dropped pair.
    for (int i = 0; i < 1026; i++)
      send_pair(16'($urandom), 16'($urandom), i == 1025);

    for (int s = 0; s < 8; s++) begin
      if (s == 4) drain_results();
      gaps_on = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 33) : $urandom_range(1, 8);
      send_series(len, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
